// ===== rtl/ske_pkg.sv =====
// Shared types, constants and the microcode program of the scalar Kalman estimator.
// Used by ske_sequencer, ske_datapath and scalar_kalman_estimator_top.
`default_nettype none

package ske_pkg;

    localparam int unsigned VAL_W   = 32;
    localparam int unsigned GAIN_W  = 17;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned SUM_W   = VAL_W + 1;
    localparam int unsigned REM_W   = VAL_W + 2;
    localparam int unsigned PROD_W  = GAIN_W + VAL_W;
    localparam int unsigned STEP_W  = 4;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [GAIN_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [VAL_W-1:0]  LOSS_BOUND   = 32'd100 * 32'd65536;
    localparam logic [VAL_W-1:0]  JITTER_BOUND = 32'd10000 * 32'd65536;
    localparam logic [VAL_W-1:0]  RTT_BOUND    = 32'd2 * 32'd65536;
    localparam logic [CNT_W-1:0]  DIV_STEPS    = 5'd16;

    localparam logic [KIND_W-1:0] KIND_LOSS   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_JITTER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RTT    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 1'd1;

    // program addresses
    localparam logic [STEP_W-1:0] ST_IDLE    = 4'd0;
    localparam logic [STEP_W-1:0] ST_PREDICT = 4'd1;
    localparam logic [STEP_W-1:0] ST_SETUP   = 4'd2;
    localparam logic [STEP_W-1:0] ST_ZCHK    = 4'd3;
    localparam logic [STEP_W-1:0] ST_DIVF    = 4'd4;
    localparam logic [STEP_W-1:0] ST_DIVS    = 4'd5;
    localparam logic [STEP_W-1:0] ST_MULX    = 4'd6;
    localparam logic [STEP_W-1:0] ST_UPDX    = 4'd7;
    localparam logic [STEP_W-1:0] ST_MULP    = 4'd8;
    localparam logic [STEP_W-1:0] ST_UPDP    = 4'd9;
    localparam logic [STEP_W-1:0] ST_COMMIT  = 4'd10;
    localparam logic [STEP_W-1:0] ST_REJECT  = 4'd11;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_PREDICT,
        OP_SETUP,
        OP_DIV_FIRST,
        OP_DIV_STEP,
        OP_MUL_X,
        OP_UPD_X,
        OP_MUL_P,
        OP_UPD_P,
        OP_COMMIT,
        OP_REJECT
    } op_t;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_IN,
        HOLD_OUT
    } hold_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_REJECT,
        COND_SUM_ZERO,
        COND_LOOP
    } cond_t;

    typedef struct packed {
        op_t               op;
        hold_t             hold;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        op_t  op;
        logic fire;
        logic in_ready;
    } ctrl_t;

    typedef struct packed {
        logic reject;
        logic sum_zero;
        logic loop_more;
        logic out_busy;
    } status_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
        ucode_t w;
        w = '{OP_NOP, HOLD_NONE, COND_NEVER, ST_IDLE};
        case (addr)
            ST_IDLE:    w = '{OP_CAPTURE,   HOLD_IN,   COND_NEVER,    ST_IDLE};
            ST_PREDICT: w = '{OP_PREDICT,   HOLD_NONE, COND_REJECT,   ST_REJECT};
            ST_SETUP:   w = '{OP_SETUP,     HOLD_NONE, COND_NEVER,    ST_IDLE};
            ST_ZCHK:    w = '{OP_NOP,       HOLD_NONE, COND_SUM_ZERO, ST_MULX};
            ST_DIVF:    w = '{OP_DIV_FIRST, HOLD_NONE, COND_NEVER,    ST_IDLE};
            ST_DIVS:    w = '{OP_DIV_STEP,  HOLD_NONE, COND_LOOP,     ST_DIVS};
            ST_MULX:    w = '{OP_MUL_X,     HOLD_NONE, COND_NEVER,    ST_IDLE};
            ST_UPDX:    w = '{OP_UPD_X,     HOLD_NONE, COND_NEVER,    ST_IDLE};
            ST_MULP:    w = '{OP_MUL_P,     HOLD_NONE, COND_NEVER,    ST_IDLE};
            ST_UPDP:    w = '{OP_UPD_P,     HOLD_NONE, COND_NEVER,    ST_IDLE};
            ST_COMMIT:  w = '{OP_COMMIT,    HOLD_OUT,  COND_ALWAYS,   ST_IDLE};
            ST_REJECT:  w = '{OP_REJECT,    HOLD_OUT,  COND_ALWAYS,   ST_IDLE};
            default:    w = '{OP_NOP,       HOLD_NONE, COND_ALWAYS,   ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ske_sequencer.sv =====
// Microcode sequencer: step counter, control ROM lookup, hold and conditional jumps.
// Depends on ske_pkg.
`default_nettype none

module ske_sequencer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire ske_pkg::status_t status,
    output ske_pkg::ctrl_t       ctrl
);
    import ske_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_t            word;
    logic              stall;
    logic              take;

    always_comb
    begin
        word = ucode_rom(step_reg);
        case (word.hold)
            HOLD_IN:  stall = !in_valid;
            HOLD_OUT: stall = status.out_busy;
            default:  stall = 1'b0;
        endcase
        case (word.cond)
            COND_ALWAYS:   take = 1'b1;
            COND_REJECT:   take = status.reject;
            COND_SUM_ZERO: take = status.sum_zero;
            COND_LOOP:     take = status.loop_more;
            default:       take = 1'b0;
        endcase
        if (stall)
        begin
            step_next = step_reg;
        end
        else if (take)
        begin
            step_next = word.target;
        end
        else
        begin
            step_next = step_reg + 4'd1;
        end
        ctrl.op       = word.op;
        ctrl.fire     = !stall;
        ctrl.in_ready = (word.hold == HOLD_IN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ske_datapath.sv =====
// Datapath: config and state registers, serial gain divider, shared 17x32 multiplier,
// result register. Executes one micro-op per cycle unless the sequencer stalls. Depends on ske_pkg.
`default_nettype none

module ske_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ske_pkg::ctrl_t                 ctrl,
    output ske_pkg::status_t                    status,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ske_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ske_pkg::VAL_W-1:0]      cfg_data,
    input  wire logic [ske_pkg::VAL_W-1:0]      sample,
    input  wire logic [ske_pkg::KIND_W-1:0]     quantity_kind,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic                                accepted,
    output logic [ske_pkg::VAL_W-1:0]           estimate,
    output logic [ske_pkg::GAIN_W-1:0]          gain,
    output logic [ske_pkg::VAL_W-1:0]           covariance
);
    import ske_pkg::*;

    logic [VAL_W-1:0]  q_reg, r_reg;
    logic [VAL_W-1:0]  x_reg, p_reg;
    logic [VAL_W-1:0]  z_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [VAL_W-1:0]  pp_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [GAIN_W-1:0] quot_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              dir_reg;
    logic [VAL_W-1:0]  diff_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [VAL_W-1:0]  xn_reg, pn_reg;
    logic              out_valid_reg;
    logic              acc_reg;
    logic [VAL_W-1:0]  est_reg, cov_reg;
    logic [GAIN_W-1:0] gain_reg;

    logic              ok;
    logic [SUM_W-1:0]  pp_wide;
    logic [VAL_W-1:0]  pp_sat;
    logic [REM_W-1:0]  rem_shift;
    logic              qbit;
    logic [GAIN_W-1:0] mul_a;
    logic [VAL_W-1:0]  mul_b;
    logic [VAL_W-1:0]  corr;
    logic              fire;

    assign fire = ctrl.fire;

    always_comb
    begin
        case (kind_reg)
            KIND_LOSS:   ok = (z_reg <= LOSS_BOUND);
            KIND_JITTER: ok = (z_reg <= JITTER_BOUND);
            KIND_RTT:    ok = (z_reg <= RTT_BOUND);
            default:     ok = 1'b0;
        endcase
        pp_wide = {1'b0, p_reg} + {1'b0, q_reg};
        pp_sat  = pp_wide[VAL_W] ? {VAL_W{1'b1}} : pp_wide[VAL_W-1:0];
        rem_shift = (ctrl.op == OP_DIV_FIRST) ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
        qbit      = (rem_shift >= {1'b0, sum_reg});
        if (ctrl.op == OP_MUL_X)
        begin
            mul_a = quot_reg;
            mul_b = diff_reg;
        end
        else
        begin
            mul_a = ONE_Q16 - quot_reg;
            mul_b = pp_reg;
        end
        corr = prod_reg[VAL_W+15:16];
    end

    assign status.reject    = !ok;
    assign status.sum_zero  = (sum_reg == '0);
    assign status.loop_more = (cnt_reg != 5'd1);
    assign status.out_busy  = out_valid_reg && !out_ready;

    // configuration and kept state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
            r_reg <= '0;
            x_reg <= '0;
            p_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en && cfg_index == REG_PROCESS_NOISE)
            begin
                q_reg <= cfg_data;
            end
            if (cfg_wr_en && cfg_index == REG_MEASUREMENT_NOISE)
            begin
                r_reg <= cfg_data;
            end
            if (fire && ctrl.op == OP_COMMIT)
            begin
                x_reg <= xn_reg;
                p_reg <= pn_reg;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            case (ctrl.op)
                OP_CAPTURE:
                begin
                    z_reg    <= sample;
                    kind_reg <= quantity_kind;
                end
                OP_PREDICT:
                begin
                    pp_reg <= pp_sat;
                end
                OP_SETUP:
                begin
                    sum_reg  <= {1'b0, pp_reg} + {1'b0, r_reg};
                    rem_reg  <= {2'b00, pp_reg};
                    quot_reg <= '0;
                    cnt_reg  <= DIV_STEPS;
                    dir_reg  <= (z_reg >= x_reg);
                    diff_reg <= (z_reg >= x_reg) ? (z_reg - x_reg) : (x_reg - z_reg);
                end
                OP_DIV_FIRST, OP_DIV_STEP:
                begin
                    rem_reg  <= qbit ? (rem_shift - {1'b0, sum_reg}) : rem_shift;
                    quot_reg <= {quot_reg[GAIN_W-2:0], qbit};
                    if (ctrl.op == OP_DIV_STEP)
                    begin
                        cnt_reg <= cnt_reg - 5'd1;
                    end
                end
                OP_MUL_X, OP_MUL_P:
                begin
                    prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
                end
                OP_UPD_X:
                begin
                    xn_reg <= dir_reg ? (x_reg + corr) : (x_reg - corr);
                end
                OP_UPD_P:
                begin
                    pn_reg <= corr;
                end
                default:
                begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && (ctrl.op == OP_COMMIT || ctrl.op == OP_REJECT))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && ctrl.op == OP_COMMIT)
        begin
            acc_reg  <= 1'b1;
            est_reg  <= xn_reg;
            gain_reg <= quot_reg;
            cov_reg  <= pn_reg;
        end
        else if (fire && ctrl.op == OP_REJECT)
        begin
            acc_reg  <= 1'b0;
            est_reg  <= x_reg;
            gain_reg <= '0;
            cov_reg  <= p_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign accepted   = acc_reg;
    assign estimate   = est_reg;
    assign gain       = gain_reg;
    assign covariance = cov_reg;

endmodule

`default_nettype wire

// ===== rtl/scalar_kalman_estimator_top.sv =====
// Top level of the scalar Kalman estimator: sequencer plus datapath.
// Depends on ske_pkg, ske_sequencer and ske_datapath.
//
// One request at a time. A request that fails the range check goes from the predict step
// straight to the reject step; when P+Q+R is zero the divider is skipped and the gain is
// zero; otherwise the gain is formed by the 17-step restoring divider, one quotient bit
// per cycle, run by the microcode loop. in_ready is high only while the sequencer sits at
// its first step, so the next request can be taken in the cycle after the result is
// written. A finished result waits in the output register while the next request is
// computed; the sequencer stalls at its last step while an earlier result is still
// unaccepted. Configuration writes take effect at once.
`default_nettype none

module scalar_kalman_estimator_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ske_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ske_pkg::VAL_W-1:0]      cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [ske_pkg::VAL_W-1:0]      sample,
    input  wire logic [ske_pkg::KIND_W-1:0]     quantity_kind,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                accepted,
    output logic [ske_pkg::VAL_W-1:0]           estimate,
    output logic [ske_pkg::GAIN_W-1:0]          gain,
    output logic [ske_pkg::VAL_W-1:0]           covariance
);
    import ske_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    ske_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .ctrl     (ctrl)
    );

    ske_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample        (sample),
        .quantity_kind (quantity_kind),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .accepted      (accepted),
        .estimate      (estimate),
        .gain          (gain),
        .covariance    (covariance)
    );

    assign in_ready = ctrl.in_ready;

`ifndef SYNTH
    // a request leaves the idle step at once
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("sequencer stayed idle after accepting a request");

    // gain is at most 1.0, and zero for a rejected request
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gain <= ONE_Q16) && (accepted || gain == '0))
        else $error("gain out of range");

    // a new result is written only as the program returns to idle
    a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result produced away from program end");
`endif

endmodule

`default_nettype wire
